[hdl/ipb_pkg.sv]
package ipb_pkg;

  // Default sizing of the bank.
  localparam int CHANNELS_DEF   = 4;
  localparam int COUNT_BITS_DEF = 21;

  // Fixed field widths.
  localparam int CHANNEL_W   = 2;
  localparam int DRIVE_W     = 8;
  localparam int GAIN_W      = 32;
  localparam int INTEG_W     = 32;
  localparam int POWER_W     = 25;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // Fixed-point formats: gains carry 24 fractional bits, power carries 16.
  localparam int FRAC_BITS = 24;
  localparam int POW_FRAC  = 16;

  // Drive and power limits.
  localparam int DRIVE_MAX = 127;
  localparam int POW_LIMIT = 128;
  localparam int POW_CLAMP = 127;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_I = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_D = 2'd2;

  // Gain values after reset.
  localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 32'sd33554;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 32'sd0;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 32'sd3355443;

  typedef struct packed {
    logic signed [GAIN_W-1:0] p;
    logic signed [GAIN_W-1:0] i;
    logic signed [GAIN_W-1:0] d;
  } gains_t;

endpackage

[hdl/ipb_if.sv]
// Command channel: one control step for one channel.
interface ipb_cmd_if
  import ipb_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [CHANNEL_W-1:0]         channel;
  logic signed [COUNT_BITS-1:0] target;
  logic signed [COUNT_BITS-1:0] measured;

  modport source (output valid, channel, target, measured, input ready);
  modport sink   (input valid, channel, target, measured, output ready);
endinterface

// Result channel: the drive command for one channel.
interface ipb_res_if
  import ipb_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [CHANNEL_W-1:0]      out_channel;
  logic signed [DRIVE_W-1:0] drive;

  modport source (output valid, out_channel, drive, input ready);
  modport sink   (input valid, out_channel, drive, output ready);
endinterface

[hdl/ipb_gain_regs.sv]
module ipb_gain_regs
  import ipb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output gains_t                 gains
);

  // Gain registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.p <= GAIN_P_RST;
      gains.i <= GAIN_I_RST;
      gains.d <= GAIN_D_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GAIN_P: gains.p <= $signed(cfg_data[GAIN_W-1:0]);
        CFG_GAIN_I: gains.i <= $signed(cfg_data[GAIN_W-1:0]);
        CFG_GAIN_D: gains.d <= $signed(cfg_data[GAIN_W-1:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

[hdl/ipb_chan_state.sv]
module ipb_chan_state
  import ipb_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int E_W       = COUNT_BITS + 1
)(
  input  logic                    clk,
  input  logic                    rst,
  input  logic [IDX_W-1:0]        idx,
  input  logic                    wr_en,
  input  logic signed [E_W-1:0]   err_wr,
  input  logic signed [INTEG_W-1:0] integ_wr,
  input  logic signed [POWER_W-1:0] power_wr,
  output logic signed [E_W-1:0]   err_rd,
  output logic signed [INTEG_W-1:0] integ_rd,
  output logic signed [POWER_W-1:0] power_rd
);

  logic signed [E_W-1:0]     prev_err [CHANNELS];
  logic signed [INTEG_W-1:0] integ    [CHANNELS];
  logic signed [POWER_W-1:0] power    [CHANNELS];

  // Per-channel controller state, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) begin
        prev_err[k] <= '0;
        integ[k]    <= '0;
        power[k]    <= '0;
      end
    end else if (wr_en) begin
      prev_err[idx] <= err_wr;
      integ[idx]    <= integ_wr;
      power[idx]    <= power_wr;
    end
  end

  // The step in flight reads its channel's state directly.
  assign err_rd   = prev_err[idx];
  assign integ_rd = integ[idx];
  assign power_rd = power[idx];

endmodule

[hdl/ipb_pid_calc.sv]
module ipb_pid_calc
  import ipb_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int E_W       = COUNT_BITS + 1
)(
  input  gains_t                      gains,
  input  logic signed [COUNT_BITS-1:0] target,
  input  logic signed [COUNT_BITS-1:0] measured,
  input  logic signed [E_W-1:0]       prev_err,
  input  logic signed [INTEG_W-1:0]   integ,
  input  logic signed [POWER_W-1:0]   power,
  output logic signed [DRIVE_W-1:0]   drive,
  output logic signed [E_W-1:0]       err_next,
  output logic signed [INTEG_W-1:0]   integ_next,
  output logic signed [POWER_W-1:0]   power_next
);

  localparam int D_W    = COUNT_BITS + 2;
  localparam int IS_W   = ((E_W > INTEG_W) ? E_W : INTEG_W) + 1;
  localparam int PE_W   = GAIN_W + E_W;
  localparam int PI_W   = GAIN_W + INTEG_W;
  localparam int PD_W   = GAIN_W + D_W;
  localparam int SHIFT  = FRAC_BITS - POW_FRAC;
  localparam int PW_W   = POWER_W + SHIFT;
  localparam int PMAX_W = (PD_W > PI_W) ? PD_W : PI_W;
  localparam int SUM_W  = PMAX_W + 2;

  localparam logic signed [IS_W-1:0] I_MAX =
    {{(IS_W - INTEG_W + 1){1'b0}}, {(INTEG_W - 1){1'b1}}};
  localparam logic signed [IS_W-1:0] I_MIN =
    {{(IS_W - INTEG_W + 1){1'b1}}, {(INTEG_W - 1){1'b0}}};

  localparam logic signed [SUM_W-1:0] S_DRV_HI = SUM_W'(DRIVE_MAX) <<< FRAC_BITS;
  localparam logic signed [SUM_W-1:0] S_DRV_LO = -S_DRV_HI;
  localparam logic signed [SUM_W-1:0] S_POW_HI = SUM_W'(POW_LIMIT) <<< FRAC_BITS;
  localparam logic signed [SUM_W-1:0] S_POW_LO = -S_POW_HI;
  localparam logic signed [SUM_W-1:0] S_ROUND  = SUM_W'((1 << SHIFT) - 1);
  localparam logic signed [POWER_W-1:0] POW_HI = POWER_W'(POW_CLAMP) <<< POW_FRAC;
  localparam logic signed [POWER_W-1:0] POW_LO = -POW_HI;
  localparam logic signed [DRIVE_W-1:0] DRV_HI = DRIVE_W'(DRIVE_MAX);
  localparam logic signed [DRIVE_W-1:0] DRV_LO = -DRV_HI;

  logic signed [E_W-1:0]     err;
  logic signed [D_W-1:0]     deriv;
  logic                      clear_integ;
  logic signed [IS_W-1:0]    isum;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [PE_W-1:0]    prod_p;
  logic signed [PI_W-1:0]    prod_i;
  logic signed [PD_W-1:0]    prod_d;
  logic signed [PW_W-1:0]    power_ext;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   sum_adj;
  logic signed [SUM_W-1:0]   sum_shr;
  logic signed [DRIVE_W-1:0] ip_low;
  logic                      frac_nz;

  // Error and derivative.
  assign err   = E_W'(target) - E_W'(measured);
  assign deriv = D_W'(err) - D_W'(prev_err);

  // The integral restarts on a zero error or a sign change against the
  // previous error, then takes the error and saturates to 32 bits.
  assign clear_integ = (err == '0) ||
                       ((err[E_W-1] != prev_err[E_W-1]) && (prev_err != '0));
  assign isum = (clear_integ ? IS_W'(0) : IS_W'(integ)) + IS_W'(err);

  always_comb begin
    if (isum > I_MAX) begin
      integ_sat = I_MAX[INTEG_W-1:0];
    end else if (isum < I_MIN) begin
      integ_sat = I_MIN[INTEG_W-1:0];
    end else begin
      integ_sat = isum[INTEG_W-1:0];
    end
  end

  // Three gain products, all at 24 fractional bits.
  assign prod_p = gains.p * err;
  assign prod_i = gains.i * integ_sat;
  assign prod_d = gains.d * deriv;

  // Power lifted to 24 fractional bits and the exact sum.
  assign power_ext = $signed({power, {SHIFT{1'b0}}});
  assign sum = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d) + SUM_W'(power_ext);

  // Drive: truncate toward zero to an integer, then saturate.
  assign frac_nz = (sum[FRAC_BITS-1:0] != '0);
  assign ip_low  = sum[FRAC_BITS +: DRIVE_W];

  always_comb begin
    if (sum >= S_DRV_HI) begin
      drive = DRV_HI;
    end else if (sum <= S_DRV_LO) begin
      drive = DRV_LO;
    end else if (sum[SUM_W-1] && frac_nz) begin
      drive = ip_low + DRIVE_W'(1);
    end else begin
      drive = ip_low;
    end
  end

  // Power update: clamp outside the limit, otherwise drop to 16 fractional
  // bits rounding toward zero.
  assign sum_adj = sum[SUM_W-1] ? (sum + S_ROUND) : sum;
  assign sum_shr = sum_adj >>> SHIFT;

  always_comb begin
    if (sum > S_POW_HI) begin
      power_next = POW_HI;
    end else if (sum < S_POW_LO) begin
      power_next = POW_LO;
    end else begin
      power_next = sum_shr[POWER_W-1:0];
    end
  end

  assign err_next   = err;
  assign integ_next = integ_sat;

endmodule

[hdl/incremental_pid_bank_core.sv]
// Bank of incremental PID controllers, one per motor channel. Each command
// transfer names a channel and carries a target and a measured encoder count;
// the block answers with one result transfer holding the channel and a drive
// command in -127..127. A command for a channel at or beyond CHANNELS leaves
// all state alone and returns a drive of zero. Throughput is one command per
// clock cycle while the result side does not stall, also for the same channel
// back to back. A command transfer fills the command register, which feeds
// the gain multiplies, the exact sum and the clamps; these settle into the
// result register when the staged command advances, while the channel state
// is written. The result register frees the command side whenever the result
// is taken or empty. The user must write gains through the configuration port
// only while no command is in flight; the block itself does not enforce it.
module incremental_pid_bank_core
  import ipb_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
)(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ipb_cmd_if.sink                cmd,
  ipb_res_if.source              res
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int E_W   = COUNT_BITS + 1;

  gains_t gains;

  logic                         stage_valid;
  logic [CHANNEL_W-1:0]         stage_channel;
  logic signed [COUNT_BITS-1:0] stage_target;
  logic signed [COUNT_BITS-1:0] stage_measured;

  logic                      res_valid;
  logic [CHANNEL_W-1:0]      res_channel;
  logic signed [DRIVE_W-1:0] res_drive;

  logic                      advance;
  logic                      in_range;
  logic [IDX_W-1:0]          idx;
  logic signed [E_W-1:0]     err_rd;
  logic signed [INTEG_W-1:0] integ_rd;
  logic signed [POWER_W-1:0] power_rd;
  logic signed [E_W-1:0]     err_next;
  logic signed [INTEG_W-1:0] integ_next;
  logic signed [POWER_W-1:0] power_next;
  logic signed [DRIVE_W-1:0] calc_drive;

  ipb_gain_regs u_gain_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains)
  );

  // The staged command moves on when the result register is empty or taken.
  assign advance   = stage_valid && (!res_valid || res.ready);
  assign cmd.ready = !stage_valid || advance;
  assign in_range  = (32'(stage_channel) < CHANNELS);
  assign idx       = IDX_W'(stage_channel);

  // Command register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd.ready) begin
      stage_valid <= cmd.valid;
    end
    if (cmd.valid && cmd.ready) begin
      stage_channel  <= cmd.channel;
      stage_target   <= cmd.target;
      stage_measured <= cmd.measured;
    end
  end

  ipb_chan_state #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_chan_state (
    .clk      (clk),
    .rst      (rst),
    .idx      (idx),
    .wr_en    (advance && in_range),
    .err_wr   (err_next),
    .integ_wr (integ_next),
    .power_wr (power_next),
    .err_rd   (err_rd),
    .integ_rd (integ_rd),
    .power_rd (power_rd)
  );

  ipb_pid_calc #(
    .COUNT_BITS (COUNT_BITS)
  ) u_pid_calc (
    .gains      (gains),
    .target     (stage_target),
    .measured   (stage_measured),
    .prev_err   (err_rd),
    .integ      (integ_rd),
    .power      (power_rd),
    .drive      (calc_drive),
    .err_next   (err_next),
    .integ_next (integ_next),
    .power_next (power_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || res.ready) begin
      res_valid <= stage_valid;
    end
    if (advance) begin
      res_channel <= stage_channel;
      res_drive   <= in_range ? calc_drive : '0;
    end
  end

  assign res.valid       = res_valid;
  assign res.out_channel = res_channel;
  assign res.drive       = res_drive;

endmodule

[hdl/ipb_checker.sv]
module ipb_checker
  import ipb_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      cmd_valid,
  input logic                      cmd_ready,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [CHANNEL_W-1:0]      out_channel,
  input logic signed [DRIVE_W-1:0] drive
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // The command side is never held off while no result is pending.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> cmd_ready)
    else $error("command stalled with an empty result register");

  // A command transfer passes from the command register to the result register
  // unless the result side stalls.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) ##1 (res_ready || !res_valid) |=> res_valid)
    else $error("accepted command did not produce a result");

  // The drive command never leaves its symmetric range.
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (drive != -8'sd128))
    else $error("drive outside saturation range");

  // A stalled result holds still.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(drive) && $stable(out_channel)))
    else $error("stalled result changed");

endmodule

bind incremental_pid_bank_core ipb_checker u_ipb_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .out_channel (res.out_channel),
  .drive       (res.drive)
);

[tb/tb_incremental_pid_bank_core.sv]
module tb_incremental_pid_bank_core;
  import ipb_pkg::*;

  localparam int COUNT_W     = COUNT_BITS_DEF;
  localparam int COUNT_MAX   = (1 << (COUNT_W - 1)) - 1;
  localparam int COUNT_MIN   = -(1 << (COUNT_W - 1));
  localparam longint INTEG_MAX = 64'sd2147483647;
  localparam longint INTEG_MIN = -64'sd2147483648;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 64;

  // Index 3 decodes to no register; writes to it must be ignored.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0]      ch;
    logic signed [DRIVE_W-1:0] drive;
  } drive_cmd_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  pace_t pace;
  int n_settings;

  ipb_cmd_if #(.COUNT_BITS(COUNT_W)) cmd_ch ();
  ipb_res_if res_ch ();

  incremental_pid_bank_core #(
    .CHANNELS(CHANNELS_DEF),
    .COUNT_BITS(COUNT_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  // Per-channel PID predictor plus the queue of drive commands still owed.
  class pid_scoreboard;
    gains_t gains;
    longint last_err [CHANNELS_DEF];
    logic signed [INTEG_W-1:0] integ_acc [CHANNELS_DEF];
    logic signed [POWER_W-1:0] power_acc [CHANNELS_DEF];
    drive_cmd_t pending_drives [$];
    int steps, checked, mismatches, drive_limits, windup_hits;

    function void clear();
      gains = '{GAIN_P_RST, GAIN_I_RST, GAIN_D_RST};
      for (int k = 0; k < CHANNELS_DEF; k++) begin
        last_err[k] = 0;
        integ_acc[k] = '0;
        power_acc[k] = '0;
      end
      pending_drives.delete();
    endfunction

    function void set_gain(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GAIN_P: gains.p = data;
        CFG_GAIN_I: gains.i = data;
        CFG_GAIN_D: gains.d = data;
        default: ;
      endcase
    endfunction

    // Works out the drive for one accepted command and advances the channel state.
    function void note_step(logic [CHANNEL_W-1:0] ch, logic signed [COUNT_W-1:0] target,
                            logic signed [COUNT_W-1:0] measured);
      longint err, prev, isum, lim;
      logic signed [127:0] total, whole;
      drive_cmd_t rec;
      lim = longint'(POW_LIMIT) <<< FRAC_BITS;
      rec.ch = ch;
      rec.drive = '0;
      steps++;
      if (ch < CHANNELS_DEF) begin
        err = target - measured;
        prev = last_err[ch];

        // The integral restarts on a zero error or a change of sign.
        if (err == 0 || (err > 0 && prev < 0) || (err < 0 && prev > 0)) begin
          isum = 0;
        end else begin
          isum = integ_acc[ch];
        end
        isum += err;
        if (isum > INTEG_MAX) begin
          isum = INTEG_MAX;
          windup_hits++;
        end else if (isum < INTEG_MIN) begin
          isum = INTEG_MIN;
          windup_hits++;
        end

        // Exact sum at 24 fractional bits; power is lifted from 16.
        total = $signed(gains.p) * err + $signed(gains.i) * isum
              + $signed(gains.d) * (err - prev)
              + power_acc[ch] * (1 << (FRAC_BITS - POW_FRAC));

        // Drive: truncate toward zero, then saturate.
        whole = total >>> FRAC_BITS;
        if (whole < 0 && total[FRAC_BITS-1:0] != '0) whole += 1;
        if (whole > DRIVE_MAX) begin
          rec.drive = DRIVE_W'(DRIVE_MAX);
        end else if (whole < -DRIVE_MAX) begin
          rec.drive = DRIVE_W'(-DRIVE_MAX);
        end else begin
          rec.drive = whole[DRIVE_W-1:0];
        end
        if (rec.drive == DRIVE_W'(DRIVE_MAX) || rec.drive == DRIVE_W'(-DRIVE_MAX)) begin
          drive_limits++;
        end

        // Power keeps the new sum, clamped just inside the limit.
        if (total > lim) begin
          power_acc[ch] = POWER_W'(POW_CLAMP <<< POW_FRAC);
        end else if (total < -lim) begin
          power_acc[ch] = POWER_W'(-(POW_CLAMP <<< POW_FRAC));
        end else begin
          power_acc[ch] = POWER_W'(total / (1 << (FRAC_BITS - POW_FRAC)));
        end

        last_err[ch] = err;
        integ_acc[ch] = INTEG_W'(isum);
      end
      pending_drives.push_back(rec);
    endfunction

    function void check_drive(logic [CHANNEL_W-1:0] ch, logic signed [DRIVE_W-1:0] drive);
      drive_cmd_t want;
      if (pending_drives.size() == 0) begin
        $error("result transfer on channel %0d with nothing outstanding", ch);
        mismatches++;
        return;
      end
      want = pending_drives.pop_front();
      checked++;
      if (ch !== want.ch) begin
        $error("out_channel: expected %0d, actual %0d", want.ch, ch);
        mismatches++;
      end
      if (drive !== want.drive) begin
        $error("drive: expected %0d, actual %0d", want.drive, drive);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction
  endclass

  pid_scoreboard sb;

  always #5 clk = ~clk;

  // Offers one command, idling first at the current sender rate.
  task automatic send_step(input logic [CHANNEL_W-1:0] ch,
                           input logic signed [COUNT_W-1:0] target,
                           input logic signed [COUNT_W-1:0] measured);
    int idle_tx;
    idle_tx = (pace == PACE_TX_SLOW) ? 86 : (pace == PACE_RX_SLOW) ? 10 : 0;
    while ($urandom_range(99) < idle_tx) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.channel <= ch;
    cmd_ch.target <= target;
    cmd_ch.measured <= measured;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    sb.note_step(ch, target, measured);
  endtask

  // Mostly settling runs on one channel with small errors; the rest is full-range noise.
  task automatic random_runs(input int count);
    int left, run, spread, base, err, k;
    logic [CHANNEL_W-1:0] ch;
    left = count;
    while (left > 0) begin
      if ($urandom_range(9) < 3) begin
        send_step(CHANNEL_W'($urandom), COUNT_W'($urandom), COUNT_W'($urandom));
        left--;
      end else begin
        ch = CHANNEL_W'($urandom);
        run = $urandom_range(12, 4);
        case ($urandom_range(2))
          0: spread = 2;
          1: spread = 300;
          default: spread = 20000;
        endcase
        base = int'($urandom_range(2000000)) - 1000000;
        for (k = 0; k < run && left > 0; k++) begin
          err = int'($urandom_range(2 * spread)) - spread;
          send_step(ch, COUNT_W'(base), COUNT_W'(base - err));
          left--;
        end
      end
    end
  endtask

  // Writes the three gains back to back, optionally poking the unused index too.
  task automatic load_gains(input logic [CFG_DATA_W-1:0] p, input logic [CFG_DATA_W-1:0] i,
                            input logic [CFG_DATA_W-1:0] d, input bit poke_unused);
    logic [CFG_INDEX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    int n, k;
    idx = '{CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D, CFG_UNUSED};
    val = '{p, i, d, CFG_DATA_W'($urandom)};
    n = poke_unused ? 4 : 3;
    for (k = 0; k < n; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      sb.set_gain(idx[k], val[k]);
    end
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  // Lets every outstanding result come back, plus a margin past the pipeline depth.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: check each transfer and pick the next ready value.
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        sb.check_drive(res_ch.out_channel, res_ch.drive);
      end
      if (!hold_done && pace == PACE_FULL) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >=
                         ((pace == PACE_RX_SLOW) ? 86 : (pace == PACE_TX_SLOW) ? 10 : 0));
      end
    end
  end

  // Ends the run if neither side completes a transfer for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $error("no transfer for %0d cycles, %0d results outstanding", quiet, sb.pending());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int ph;
    sb = new;
    sb.clear();
    n_settings = 1;
    pace = PACE_RX_SLOW;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.channel = '0;
    cmd_ch.target = '0;
    cmd_ch.measured = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed steps at the reset gains: zero error, field extremes, sign flips.
    send_step(2'd0, 0, 0);
    send_step(2'd1, COUNT_W'(COUNT_MAX), COUNT_W'(COUNT_MIN));
    send_step(2'd1, COUNT_W'(COUNT_MAX), COUNT_W'(COUNT_MIN));
    send_step(2'd1, COUNT_W'(COUNT_MIN), COUNT_W'(COUNT_MAX));
    send_step(2'd1, COUNT_W'(COUNT_MIN), COUNT_W'(COUNT_MIN));
    send_step(2'd2, 1, 0);
    send_step(2'd2, 0, 1);
    send_step(2'd2, -1, -1);
    send_step(2'd3, COUNT_W'(COUNT_MAX), COUNT_W'(COUNT_MAX));
    send_step(2'd3, COUNT_W'(COUNT_MIN), 0);
    send_step(2'd3, COUNT_W'(COUNT_MIN), 0);
    send_step(2'd0, 1000, 0);
    send_step(2'd0, 1000, 990);
    send_step(2'd0, 1000, 1010);
    send_step(2'd2, 0, COUNT_W'(COUNT_MIN));
    send_step(2'd3, 0, COUNT_W'(COUNT_MAX));
    drain();

    // Random phases, each under its own gain setting; pairs of phases share a pacing.
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        1: load_gains(32'(int'($urandom_range(1 << 23)) - (1 << 22)),
                      32'($urandom_range(4096)),
                      32'(int'($urandom_range(1 << 23)) - (1 << 22)), 1'b1);
        2: load_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        3: load_gains(32'(int'($urandom_range(1 << 25)) - (1 << 24)),
                      32'(-int'($urandom_range(4096))),
                      32'(int'($urandom_range(1 << 25)) - (1 << 24)), 1'b0);
        4: load_gains($urandom, $urandom, $urandom, 1'b0);
        default: load_gains('0, '0, '0, 1'b0);
      endcase
      pace = (ph < 2) ? PACE_RX_SLOW : (ph < 4) ? PACE_TX_SLOW : PACE_FULL;
      random_runs(115);
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Checked %0d drive results from %0d control steps over %0d gain settings.",
             sb.checked, sb.steps, n_settings);
    $display("Drive reached its limit %0d times; the integral saturated %0d times.",
             sb.drive_limits, sb.windup_hits);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
